// ===== hw/rtl/dpq_pkg.sv =====
// ---------------------------------------------------------------------------
// dpq_pkg
// shared types and constants of the deadline priority queue
// ---------------------------------------------------------------------------
package dpq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DUE_W         = 16;
   localparam int TAG_W         = 16;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 5;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [DUE_W-1:0] due;
      logic [TAG_W-1:0] tag;
   } slot_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ADD,
      CELL_SHIFT,
      CELL_SWAP
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic             parity;
      logic [DUE_W-1:0] due;
      logic [TAG_W-1:0] tag;
   } cell_cmd_type;

endpackage

// ===== hw/rtl/dpq_cell.sv =====
// ---------------------------------------------------------------------------
// dpq_cell
// one slot of the sorted chain: insert, shift toward the head, pairwise swap
// ---------------------------------------------------------------------------
module dpq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dpq_pkg::cell_cmd_type cmd,
   input  logic                  cell_odd,
   input  dpq_pkg::slot_type     left_slot,
   input  logic                  left_gt,
   input  dpq_pkg::slot_type     right_slot,
   output dpq_pkg::slot_type     slot,
   output logic                  gt
);
   import dpq_pkg::*;

   logic             valid_ff, valid_in;
   logic [DUE_W-1:0] due_ff, due_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   always_comb begin
      gt       = valid_ff && (due_ff > cmd.due);
      valid_in = valid_ff;
      due_in   = due_ff;
      tag_in   = tag_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_ADD: begin
            if (left_gt) begin
               valid_in = 1'b1;
               due_in   = left_slot.due;
               tag_in   = left_slot.tag;
            end else if (gt || (!valid_ff && left_slot.valid)) begin
               valid_in = 1'b1;
               due_in   = cmd.due;
               tag_in   = cmd.tag;
            end
         end
         CELL_SHIFT: begin
            valid_in = right_slot.valid;
            due_in   = right_slot.due;
            tag_in   = right_slot.tag;
         end
         CELL_SWAP: begin
            if (cmd.parity == cell_odd) begin
               if (!valid_ff && right_slot.valid) begin
                  valid_in = right_slot.valid;
                  due_in   = right_slot.due;
                  tag_in   = right_slot.tag;
               end
            end else if (!left_slot.valid && valid_ff) begin
               valid_in = left_slot.valid;
               due_in   = left_slot.due;
               tag_in   = left_slot.tag;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      due_ff <= due_in;
      tag_ff <= tag_in;
   end

   assign slot.valid = valid_ff;
   assign slot.due   = due_ff;
   assign slot.tag   = tag_ff;

endmodule

// ===== hw/rtl/deadline_priority_queue.sv =====
// ---------------------------------------------------------------------------
// deadline_priority_queue
// earliest-deadline-first queue built as a chain of DEPTH sorted cells
// ---------------------------------------------------------------------------
// Add, pop and the unused mode need no busy phase: the word is accepted while
// busy is low and its result strobes on rsp_valid in the next cycle, and a
// new start can be accepted in that same cycle. Remove keeps busy high for
// one full rotation of the cell chain through the head, which counts and marks
// matching tags, then DEPTH odd-even compaction passes that close the gaps;
// its result strobes in the same cycle that busy falls. Results are shown
// for exactly one cycle and cannot be held off by the receiver.
// Equal deadlines leave in arrival order; an add to a full queue is dropped
// with status full.
module deadline_priority_queue #(
   parameter int DEPTH = dpq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dpq_pkg::MODE_W-1:0]        req_mode,
   input  logic [dpq_pkg::TAG_W-1:0]         req_task_tag,
   input  logic [dpq_pkg::DUE_W-1:0]         req_due_value,
   output logic                              rsp_valid,
   output logic [dpq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [dpq_pkg::TAG_W-1:0]         rsp_out_tag,
   output logic [dpq_pkg::DUE_W-1:0]         rsp_out_due,
   output logic [dpq_pkg::COUNT_OUT_W-1:0]   rsp_removed_count,
   output logic [dpq_pkg::COUNT_OUT_W-1:0]   rsp_occupancy
);
   import dpq_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int STEP_W = $clog2(DEPTH);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_COMPACT
   } state_type;

   state_type                state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         removed_ff, removed_in;
   logic [TAG_W-1:0]         match_tag_ff, match_tag_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]         rsp_out_tag_ff, rsp_out_tag_in;
   logic [DUE_W-1:0]         rsp_out_due_ff, rsp_out_due_in;
   logic [COUNT_OUT_W-1:0]   rsp_removed_ff, rsp_removed_in;
   logic [COUNT_OUT_W-1:0]   rsp_occupancy_ff, rsp_occupancy_in;

   cell_cmd_type             cmd;
   slot_type                 cell_slot [DEPTH];
   logic                     cell_gt [DEPTH];
   slot_type                 head_slot;
   slot_type                 tail_slot;
   logic [DEPTH-1:0]         valid_vec;
   logic                     head_match;

   assign head_slot.valid = 1'b1;
   assign head_slot.due   = '0;
   assign head_slot.tag   = '0;

   assign head_match = cell_slot[0].valid && (cell_slot[0].tag == match_tag_ff);

   always_comb begin
      tail_slot.valid = (state_ff == ST_ROTATE) && cell_slot[0].valid
                        && (cell_slot[0].tag != match_tag_ff);
      tail_slot.due   = cell_slot[0].due;
      tail_slot.tag   = cell_slot[0].tag;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      slot_type left_slot;
      logic     left_gt;
      slot_type right_slot;

      if (i == 0) begin : g_head
         assign left_slot = head_slot;
         assign left_gt   = 1'b0;
      end else begin : g_mid_left
         assign left_slot = cell_slot[i-1];
         assign left_gt   = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_slot = tail_slot;
      end else begin : g_mid_right
         assign right_slot = cell_slot[i+1];
      end

      dpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cell_odd   (1'(i % 2)),
         .left_slot  (left_slot),
         .left_gt    (left_gt),
         .right_slot (right_slot),
         .slot       (cell_slot[i]),
         .gt         (cell_gt[i])
      );

      assign valid_vec[i] = cell_slot[i].valid;
   end

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      count_in         = count_ff;
      removed_in       = removed_ff;
      match_tag_in     = match_tag_ff;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = STATUS_OK;
      rsp_out_tag_in   = '0;
      rsp_out_due_in   = '0;
      rsp_removed_in   = '0;
      cmd.op           = CELL_HOLD;
      cmd.parity       = step_ff[0];
      cmd.due          = req_due_value;
      cmd.tag          = req_task_tag;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  MODE_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_FULL) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.op   = CELL_ADD;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_POP: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cmd.op         = CELL_SHIFT;
                        rsp_out_tag_in = cell_slot[0].tag;
                        rsp_out_due_in = cell_slot[0].due;
                        count_in       = count_ff - 1'b1;
                     end
                  end
                  MODE_REMOVE: begin
                     match_tag_in = req_task_tag;
                     removed_in   = '0;
                     step_in      = '0;
                     state_in     = ST_ROTATE;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ROTATE: begin
            cmd.op     = CELL_SHIFT;
            removed_in = removed_ff + CNT_W'(head_match);
            step_in    = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = ST_COMPACT;
            end
         end
         ST_COMPACT: begin
            cmd.op  = CELL_SWAP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               step_in        = '0;
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_removed_in = COUNT_OUT_W'(removed_ff);
               count_in       = count_ff - removed_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_occupancy_in = COUNT_OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      match_tag_ff     <= match_tag_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_out_tag_ff   <= rsp_out_tag_in;
      rsp_out_due_ff   <= rsp_out_due_in;
      rsp_removed_ff   <= rsp_removed_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_tag       = rsp_out_tag_ff;
   assign rsp_out_due       = rsp_out_due_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_occupancy     = rsp_occupancy_ff;

   // valid cells always form a prefix from the head when idle
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> $onehot({1'b0, valid_vec} + (DEPTH + 1)'(1)))
      else $error("valid cells do not form a prefix");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff == CNT_W'($countones(valid_vec))))
      else $error("occupancy counter disagrees with cell chain");

   a_no_word_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid_ff)
      else $error("result word while a remove is in progress");

   a_single_cycle_ops: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode != MODE_REMOVE)) |=> rsp_valid_ff)
      else $error("single-cycle operation gave no result word");

   a_remove_enters_rotate: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == MODE_REMOVE)) |=> (state_ff == ST_ROTATE))
      else $error("remove did not start the rotation pass");

endmodule
